>>> hdl/dpfa_pkg.sv
// shared constants and types for the binary64 adder pipeline
// no dependencies
package dpfa_pkg;
    localparam int ExpW = 11;
    localparam int ManW = 52;
    localparam int GuardW = 9;
    localparam int SigW = 63;
    localparam int LzcW = 6;
    localparam logic [ExpW-1:0] ExpMax = 11'h7ff;
    localparam logic [63:0] DefaultNan = 64'hffffffffffffffff;
    localparam logic [63:0] InfBits = 64'h7ff0000000000000;

    typedef struct packed {
        logic            special;
        logic [63:0]     special_bits;
        logic            invalid;
        logic            sign;
        logic            is_sub;
        logic [ExpW:0]   exp_big;
        logic [SigW-1:0] sig_big;
        logic [SigW-1:0] sig_small;
    } align_t;

    typedef struct packed {
        logic            special;
        logic [63:0]     special_bits;
        logic            invalid;
        logic            sign;
        logic [ExpW:0]   exp;
        logic [SigW-1:0] sig;
    } norm_t;
endpackage

>>> hdl/dpfa_align.sv
// stage one: special case detection, operand swap and alignment shift
// depends on dpfa_pkg
module dpfa_align (
    input  logic [63:0]     operand_a,
    input  logic [63:0]     operand_b,
    output dpfa_pkg::align_t result
);
    import dpfa_pkg::*;

    logic a_spec, b_spec, a_nan, b_nan, a_snan, b_snan;
    logic [63:0] big, little;
    logic [ExpW:0] e_big, e_little, d;
    logic [SigW-1:0] m_big, m_little, lost_mask;

    always_comb
    begin
        a_spec = operand_a[62:52] == ExpMax;
        b_spec = operand_b[62:52] == ExpMax;
        a_nan = a_spec && (operand_a[51:0] != '0);
        b_nan = b_spec && (operand_b[51:0] != '0);
        a_snan = a_nan && !operand_a[51];
        b_snan = b_nan && !operand_b[51];
        result.special = a_spec || b_spec;
        result.invalid = 1'b0;
        result.special_bits = operand_a;
        if (a_nan && b_nan)
        begin
            result.invalid = a_snan || b_snan;
            result.special_bits = (operand_a > operand_b) ? operand_a : operand_b;
        end
        else if (a_nan)
        begin
            result.invalid = a_snan;
        end
        else if (b_nan)
        begin
            result.invalid = b_snan;
            result.special_bits = operand_b;
        end
        else if (a_spec && b_spec)
        begin
            if (operand_a != operand_b)
            begin
                result.special_bits = DefaultNan;
                result.invalid = 1'b1;
            end
        end
        else if (b_spec)
        begin
            result.special_bits = operand_b;
        end

        if (operand_b[62:0] > operand_a[62:0])
        begin
            big = operand_b;
            little = operand_a;
        end
        else
        begin
            big = operand_a;
            little = operand_b;
        end
        result.sign = big[63];
        result.is_sub = operand_a[63] ^ operand_b[63];
        e_big = {1'b0, big[62:52]};
        e_little = {1'b0, little[62:52]};
        m_big = {1'b0, (e_big != '0), big[51:0], {GuardW{1'b0}}};
        m_little = {1'b0, (e_little != '0), little[51:0], {GuardW{1'b0}}};
        if (e_big == '0)
            e_big = 12'd1;
        if (e_little == '0)
            e_little = 12'd1;
        d = e_big - e_little;
        lost_mask = ~({SigW{1'b1}} << d[5:0]);
        if (d > 12'd62)
        begin
            m_little = {{(SigW-1){1'b0}}, (m_little != '0)};
        end
        else
        begin
            m_little = (m_little >> d[5:0])
                     | {{(SigW-1){1'b0}}, ((m_little & lost_mask) != '0)};
        end
        result.exp_big = e_big;
        result.sig_big = m_big;
        result.sig_small = m_little;
    end
endmodule

>>> hdl/dpfa_norm.sv
// stage three: leading zero count and normalization shift
// depends on dpfa_pkg
module dpfa_norm (
    input  dpfa_pkg::norm_t din,
    output dpfa_pkg::norm_t dout
);
    import dpfa_pkg::*;

    logic [LzcW-1:0] lz, sh;
    logic [ExpW:0] room;

    always_comb
    begin
        lz = LzcW'(61);
        for (int i = 0; i < 62; i++)
        begin
            if (din.sig[i])
                lz = LzcW'(61 - i);
        end
        room = din.exp - 12'd1;
        sh = (room < {6'd0, lz}) ? room[LzcW-1:0] : lz;
        dout = din;
        if (din.sig[62])
        begin
            dout.sig = {1'b0, din.sig[62:2], din.sig[1] | din.sig[0]};
            dout.exp = din.exp + 12'd1;
        end
        else
        begin
            dout.sig = din.sig << sh;
            dout.exp = din.exp - {6'd0, sh};
        end
    end
endmodule

>>> hdl/double_precision_float_adder_core.sv
// binary64 adder, round to nearest even, four register stages
// input passes through the align, add, normalize and round registers, one word per cycle unless the output stalls
// pipeline advances whenever the output register is free or being taken
// asynchronous active low reset clears the valid bits only
// depends on dpfa_pkg, dpfa_align, dpfa_norm
module double_precision_float_adder_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // operand_b (upper half), operand_a (lower half)
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,  // sum_bits
    output logic         m_axis_tuser   // invalid_op
);
    import dpfa_pkg::*;

    logic [3:0] vld_reg;
    logic advance;
    align_t al_comb, al_reg;
    norm_t ad_next, ad_reg, nm_comb, nm_reg;
    logic [63:0] sum_reg, sum_next;
    logic inv_reg, inv_next;
    logic [SigW-1:0] m;
    logic [53:0] keep;
    logic [8:0] rem;
    logic [63:0] bits;

    assign advance = !vld_reg[3] || m_axis_tready;
    assign s_axis_tready = advance;
    assign m_axis_tvalid = vld_reg[3];
    assign m_axis_tdata = sum_reg;
    assign m_axis_tuser = inv_reg;

    dpfa_align u_align (
        .operand_a(s_axis_tdata[63:0]),
        .operand_b(s_axis_tdata[127:64]),
        .result   (al_comb)
    );

    always_comb
    begin
        ad_next.special = al_reg.special;
        ad_next.special_bits = al_reg.special_bits;
        ad_next.invalid = al_reg.invalid;
        ad_next.sign = al_reg.sign;
        ad_next.exp = al_reg.exp_big;
        m = al_reg.is_sub ? al_reg.sig_big - al_reg.sig_small
                          : al_reg.sig_big + al_reg.sig_small;
        ad_next.sig = m;
        if (m == '0 && !al_reg.special)
        begin
            ad_next.special = 1'b1;
            ad_next.special_bits = {al_reg.sign & !al_reg.is_sub, 63'd0};
        end
    end

    dpfa_norm u_norm (
        .din (ad_reg),
        .dout(nm_comb)
    );

    always_comb
    begin
        keep = {1'b0, nm_reg.sig[61:9]};
        rem = nm_reg.sig[8:0];
        if (rem > 9'h100 || (rem == 9'h100 && keep[0]))
            keep = keep + 54'd1;
        bits = ({53'd0, (nm_reg.exp[10:0] - 11'd1)} << 52) + {10'd0, keep};
        inv_next = nm_reg.invalid;
        if (nm_reg.special)
            sum_next = nm_reg.special_bits;
        else if (bits >= InfBits)
            sum_next = {nm_reg.sign, InfBits[62:0]};
        else
            sum_next = {nm_reg.sign, bits[62:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= {vld_reg[2:0], s_axis_tvalid};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            al_reg <= al_comb;
            ad_reg <= ad_next;
            nm_reg <= nm_comb;
            sum_reg <= sum_next;
            inv_reg <= inv_next;
        end
    end
endmodule

>>> hdl/dpfa_checker.sv
// port level checks for the binary64 adder
// depends on double_precision_float_adder_core
module dpfa_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [63:0]  m_axis_tdata,
    input logic         m_axis_tuser
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word dropped while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !$isunknown({m_axis_tdata, m_axis_tuser}))
        else $error("unknown bits in output word");
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && m_axis_tready ##1 m_axis_tready ##1
        m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("latency violated");
endmodule

bind double_precision_float_adder_core dpfa_checker u_dpfa_checker (.*);
